// ===== rtl/core/tsfvf_pkg.sv =====
// shared constants, types and helpers for the two-sensor force fusion block
// no dependencies
package tsfvf_pkg;

    localparam int FRAC_BITS_DEF    = 16;
    localparam int CORDIC_STEPS_DEF = 16;
    localparam int ATAN_LEN         = 24;
    localparam int DW               = 40;   // datapath width, covers guard bits and growth
    localparam int ZW               = 34;   // Q2.30 angle width with headroom

    localparam logic signed [ZW-1:0] HALF_PI_Q30 = 34'sd1686629713;
    localparam logic signed [ZW-1:0] PI_Q30      = 34'sd3373259426;

    typedef enum logic [1:0] {
        REG_MOUNT_A   = 2'd0,
        REG_MOUNT_B   = 2'd1,
        REG_THRESHOLD = 2'd2
    } reg_idx_t;

    typedef logic signed [DW-1:0] dat_t;
    typedef logic signed [ZW-1:0] ang_t;

    function automatic ang_t atan_q30(input int i);
        ang_t r;
        r = '0;
        case (i)
            0:  r = 34'sd843314857;
            1:  r = 34'sd497837829;
            2:  r = 34'sd263043837;
            3:  r = 34'sd133525159;
            4:  r = 34'sd67021687;
            5:  r = 34'sd33543516;
            6:  r = 34'sd16775851;
            7:  r = 34'sd8388437;
            8:  r = 34'sd4194283;
            9:  r = 34'sd2097149;
            10: r = 34'sd1048576;
            11: r = 34'sd524288;
            12: r = 34'sd262144;
            13: r = 34'sd131072;
            14: r = 34'sd65536;
            15: r = 34'sd32768;
            16: r = 34'sd16384;
            17: r = 34'sd8192;
            18: r = 34'sd4096;
            19: r = 34'sd2048;
            20: r = 34'sd1024;
            21: r = 34'sd512;
            22: r = 34'sd256;
            23: r = 34'sd128;
            default: r = '0;
        endcase
        return r;
    endfunction

    // squared cordic gain, q30, worked out at elaboration
    function automatic longint cordic_gain_sq_q30(input int steps);
        longint p;
        p = 64'sd1 << 30;
        for (int i = 0; i < steps; i++)
            p = p + (p >>> (2 * i));
        return p;
    endfunction

endpackage

// ===== rtl/core/tsfvf_rot.sv =====
// pipelined rotation-mode cordic, one micro-rotation per stage
// depends on tsfvf_pkg
module tsfvf_rot #(
    parameter int FRAC_BITS    = tsfvf_pkg::FRAC_BITS_DEF,
    parameter int CORDIC_STEPS = tsfvf_pkg::CORDIC_STEPS_DEF
) (
    input  logic                 clk,
    input  logic signed [31:0]   x_in,
    input  logic signed [31:0]   y_in,
    input  logic signed [18:0]   ang_in,
    output tsfvf_pkg::dat_t      x_out,
    output tsfvf_pkg::dat_t      y_out
);
    import tsfvf_pkg::*;

    localparam int ANG_SHIFT = 30 - FRAC_BITS;

    dat_t x_reg [CORDIC_STEPS+1];
    dat_t y_reg [CORDIC_STEPS+1];
    ang_t z_reg [CORDIC_STEPS+1];

    dat_t xs0, ys0, xs1, ys1;
    ang_t zs0, zs1;

    // quarter-turn prerotation, checked twice
    always_comb
    begin
        xs0 = DW'(x_in) <<< 4;
        ys0 = DW'(y_in) <<< 4;
        zs0 = ZW'(ang_in) <<< ANG_SHIFT;
        xs1 = xs0; ys1 = ys0; zs1 = zs0;
        if (zs0 > HALF_PI_Q30)
        begin
            xs1 = -ys0; ys1 = xs0; zs1 = zs0 - HALF_PI_Q30;
        end
        else if (zs0 < -HALF_PI_Q30)
        begin
            xs1 = ys0; ys1 = -xs0; zs1 = zs0 + HALF_PI_Q30;
        end
        xs0 = xs1; ys0 = ys1; zs0 = zs1;
        if (zs1 > HALF_PI_Q30)
        begin
            xs0 = -ys1; ys0 = xs1; zs0 = zs1 - HALF_PI_Q30;
        end
        else if (zs1 < -HALF_PI_Q30)
        begin
            xs0 = ys1; ys0 = -xs1; zs0 = zs1 + HALF_PI_Q30;
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg[0] <= xs0;
        y_reg[0] <= ys0;
        z_reg[0] <= zs0;
    end

    for (genvar i = 0; i < CORDIC_STEPS; i++)
    begin : g_step
        always_ff @(posedge clk)
        begin
            if (z_reg[i] >= 0)
            begin
                x_reg[i+1] <= x_reg[i] - (y_reg[i] >>> i);
                y_reg[i+1] <= y_reg[i] + (x_reg[i] >>> i);
                z_reg[i+1] <= z_reg[i] - atan_q30(i);
            end
            else
            begin
                x_reg[i+1] <= x_reg[i] + (y_reg[i] >>> i);
                y_reg[i+1] <= y_reg[i] - (x_reg[i] >>> i);
                z_reg[i+1] <= z_reg[i] + atan_q30(i);
            end
        end
    end

    assign x_out = x_reg[CORDIC_STEPS];
    assign y_out = y_reg[CORDIC_STEPS];

endmodule

// ===== rtl/core/two_sensor_force_vector_fusion.sv =====
// top level of the two-sensor force fusion block
// depends on tsfvf_pkg and tsfvf_rot
// path: prerotation register, rotation stages, sum, half-plane fold, vectoring stages,
// partial-product registers, product register and output register
// throughput: one beat per cycle, the cordic stages are fully pipelined
// busy is held low, the receiver cannot stall and each result shows for one cycle
// reset clears the configuration registers to zero and the valid pipeline; data registers keep no reset
module two_sensor_force_vector_fusion #(
    parameter int FRAC_BITS    = tsfvf_pkg::FRAC_BITS_DEF,
    parameter int CORDIC_STEPS = tsfvf_pkg::CORDIC_STEPS_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    output logic                busy,
    input  logic signed [31:0]  sensor_a_x,
    input  logic signed [31:0]  sensor_a_y,
    input  logic signed [31:0]  sensor_b_x,
    input  logic signed [31:0]  sensor_b_y,
    input  logic signed [18:0]  heading_offset,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [1:0]          cfg_index,
    input  logic [31:0]         cfg_data,
    output logic                out_valid,
    output logic [30:0]         force_magnitude,
    output logic signed [19:0]  force_angle
);
    import tsfvf_pkg::*;

    localparam int ANG_SHIFT = 30 - FRAC_BITS;
    localparam int LAT       = 2 * CORDIC_STEPS + 6;
    localparam longint GAIN_SQ = cordic_gain_sq_q30(CORDIC_STEPS);
    localparam logic [27:0] GAIN = 28'(((64'sd1 <<< 54) + (GAIN_SQ >>> 1)) / GAIN_SQ);

    // configuration registers
    logic signed [18:0] mount_a_reg, mount_b_reg;
    logic [30:0]        thr_reg;

    assign cfg_ready = 1'b1;
    assign busy      = 1'b0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mount_a_reg <= '0;
            mount_b_reg <= '0;
            thr_reg     <= '0;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                REG_MOUNT_A:   mount_a_reg <= cfg_data[18:0];
                REG_MOUNT_B:   mount_b_reg <= cfg_data[18:0];
                REG_THRESHOLD: thr_reg     <= cfg_data[30:0];
                default: ;
            endcase
        end
    end

    // valid bits travel alongside the data
    logic [LAT-1:0] vld_reg;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else
            vld_reg <= {vld_reg[LAT-2:0], start};
    end

    // heading rides a delay line of the same length
    logic signed [18:0] hd_reg [LAT];
    always_ff @(posedge clk)
    begin
        hd_reg[0] <= heading_offset;
        for (int k = 1; k < LAT; k++)
            hd_reg[k] <= hd_reg[k-1];
    end

    // two rotation cordics in parallel
    dat_t ax, ay, bx, by;
    tsfvf_rot #(.FRAC_BITS(FRAC_BITS), .CORDIC_STEPS(CORDIC_STEPS)) u_rot_a (
        .clk(clk), .x_in(sensor_a_x), .y_in(sensor_a_y), .ang_in(mount_a_reg),
        .x_out(ax), .y_out(ay));
    tsfvf_rot #(.FRAC_BITS(FRAC_BITS), .CORDIC_STEPS(CORDIC_STEPS)) u_rot_b (
        .clk(clk), .x_in(sensor_b_x), .y_in(sensor_b_y), .ang_in(mount_b_reg),
        .x_out(bx), .y_out(by));

    // sum and half-plane fold
    dat_t sx_reg, sy_reg;
    always_ff @(posedge clk)
    begin
        sx_reg <= ax + bx;
        sy_reg <= ay + by;
    end

    dat_t vx_reg [CORDIC_STEPS+1];
    dat_t vy_reg [CORDIC_STEPS+1];
    ang_t vz_reg [CORDIC_STEPS+1];
    logic nz_reg [CORDIC_STEPS+1];

    always_ff @(posedge clk)
    begin
        nz_reg[0] <= (sx_reg != 0) || (sy_reg != 0);
        if (sx_reg < 0)
        begin
            vx_reg[0] <= -sx_reg;
            vy_reg[0] <= -sy_reg;
            vz_reg[0] <= (sy_reg >= 0) ? PI_Q30 : -PI_Q30;
        end
        else
        begin
            vx_reg[0] <= sx_reg;
            vy_reg[0] <= sy_reg;
            vz_reg[0] <= '0;
        end
    end

    // vectoring stages; a zero vector passes through untouched
    for (genvar i = 0; i < CORDIC_STEPS; i++)
    begin : g_vec
        always_ff @(posedge clk)
        begin
            nz_reg[i+1] <= nz_reg[i];
            if (!nz_reg[i])
            begin
                vx_reg[i+1] <= vx_reg[i];
                vy_reg[i+1] <= vy_reg[i];
                vz_reg[i+1] <= vz_reg[i];
            end
            else if (vy_reg[i] >= 0)
            begin
                vx_reg[i+1] <= vx_reg[i] + (vy_reg[i] >>> i);
                vy_reg[i+1] <= vy_reg[i] - (vx_reg[i] >>> i);
                vz_reg[i+1] <= vz_reg[i] + atan_q30(i);
            end
            else
            begin
                vx_reg[i+1] <= vx_reg[i] - (vy_reg[i] >>> i);
                vy_reg[i+1] <= vy_reg[i] + (vx_reg[i] >>> i);
                vz_reg[i+1] <= vz_reg[i] - atan_q30(i);
            end
        end
    end

    // gain correction, multiply split into two 20x28 partial products
    dat_t xf;
    ang_t zf;
    assign xf = vx_reg[CORDIC_STEPS];
    assign zf = vz_reg[CORDIC_STEPS];

    logic [19:0]        xlo_next;
    logic signed [19:0] xhi_next;
    assign xlo_next = xf[19:0];
    assign xhi_next = xf[DW-1:20];

    logic [47:0]        plo_reg;
    logic signed [48:0] phi_reg;
    ang_t               z1_reg, z2_reg;
    always_ff @(posedge clk)
    begin
        plo_reg <= xlo_next * GAIN;
        phi_reg <= xhi_next * $signed({1'b0, GAIN});
        z1_reg  <= zf;
    end

    logic signed [71:0] prod_reg;
    always_ff @(posedge clk)
    begin
        prod_reg <= (72'(phi_reg) <<< 20) + $signed({24'd0, plo_reg}) + (72'sd1 <<< 27);
        z2_reg   <= z1_reg;
    end

    // saturate, round angle, gate and add heading
    logic signed [43:0] mag_full;
    logic [30:0]        mag_sat;
    ang_t               z_rnd;
    logic signed [19:0] ang_next;
    logic [30:0]        mag_next;
    assign mag_full = prod_reg[71:28];
    assign z_rnd    = (z2_reg + (ZW'(1) <<< (ANG_SHIFT - 1))) >>> ANG_SHIFT;

    always_comb
    begin
        if (mag_full < 0)
            mag_sat = '0;
        else if (mag_full > 44'sh7FFFFFFF)
            mag_sat = 31'h7FFFFFFF;
        else
            mag_sat = mag_full[30:0];
        if (mag_sat < thr_reg)
        begin
            mag_next = '0;
            ang_next = 20'(hd_reg[LAT-2]);
        end
        else
        begin
            mag_next = mag_sat;
            ang_next = 20'(z_rnd) + 20'(hd_reg[LAT-2]);
        end
    end

    always_ff @(posedge clk)
    begin
        force_magnitude <= mag_next;
        force_angle     <= ang_next;
    end

    assign out_valid = vld_reg[LAT-1];

    // every start is answered by an out_valid beat, and no out_valid beat comes without a start
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        start |-> ##LAT out_valid) else $error("result beat missing");
    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> $past(start, LAT)) else $error("result beat without start");
    a_gate: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && force_magnitude != 0 |-> $past(mag_sat >= thr_reg))
        else $error("gated magnitude leaked");

endmodule
